[rtl/line_junction_classifier_core_assert.svh]
// Assertion helpers for the junction classifier.
// All checks sample on clk and are masked while rst_n is low.
`ifndef LINE_JUNCTION_CLASSIFIER_CORE_ASSERT_SVH
`define LINE_JUNCTION_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication.
`define LJC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LJC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ljc_pkg.sv]
// ----------------------------------------------------------------------------
// ljc_pkg
// Types and constants shared by the line junction classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ljc_pkg;

  // Crossing kinds
  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_DEAD_END = 3'd1;
  localparam logic [2:0] KIND_FOUR_WAY = 3'd2;
  localparam logic [2:0] KIND_T_LR     = 3'd3;
  localparam logic [2:0] KIND_LEFT_STR = 3'd4;
  localparam logic [2:0] KIND_RIGHT_STR = 3'd5;

  // Commands
  localparam logic [2:0] CMD_IDLE      = 3'd0;
  localparam logic [2:0] CMD_RIGHT_90  = 3'd1;
  localparam logic [2:0] CMD_LEFT_90   = 3'd2;
  localparam logic [2:0] CMD_FWD_40    = 3'd3;
  localparam logic [2:0] CMD_RIGHT_180 = 3'd4;
  localparam logic [2:0] CMD_AHEAD     = 3'd5;

  localparam logic [7:0] AMOUNT_180 = 8'd180;
  localparam logic [7:0] AMOUNT_90  = 8'd90;
  localparam logic [7:0] AMOUNT_40  = 8'd40;

  // Sensor patterns, bit 7 outer right .. bit 0 outer left
  localparam logic [7:0] DEAD_MASK  = 8'b0011_1100;
  localparam logic [7:0] BOTH_MASK  = 8'b1110_0111;
  localparam logic [7:0] RIGHT_MASK = 8'b1110_0000;
  localparam logic [7:0] LEFT_MASK  = 8'b0000_0111;
  localparam logic [7:0] EDGE_MASK  = 8'b0010_0100;
  localparam logic [7:0] MID_MASK   = 8'b0001_1000;

  // Register map (word index)
  localparam logic [1:0] REG_CONFIRM = 2'd0;
  localparam logic [1:0] REG_IDLE    = 2'd1;
  localparam logic [1:0] REG_SPEED   = 2'd2;

  localparam logic [3:0] CONFIRM_RST = 4'd5;
  localparam logic [7:0] IDLE_RST    = 8'd10;
  localparam logic [7:0] SPEED_RST   = 8'd100;

  typedef struct packed {
    logic [7:0] line_sensors;
    logic       timed_out;
    logic       motion_busy;
  } ljc_in_t;

  typedef struct packed {
    logic [2:0] junction_kind;
    logic [2:0] command_code;
    logic [7:0] move_amount;
    logic       turn_right;
    logic       rotate_flag;
    logic       move_flag;
    logic [7:0] wheel_speed;
  } ljc_out_t;

endpackage

`default_nettype wire

[rtl/line_junction_classifier_core.sv]
// Line junction classifier.
// Input channel in_valid/in_stall/in_data carries one sensor word per
// evaluation tick (sensor bits, timeout flag, motion-busy flag). Each input
// word yields exactly one result word on out_valid/out_stall/out_data: the
// crossing kind found so far and the current turn command.
// Timing: an accepted word is held in the input register; the detector state
// and result register update from it when the result register is free or
// being taken, and out_valid rises with that update. One word per cycle is
// sustained while the receiver does not stall; the bound is the combinational
// detector update feeding the result register.
// When the receiver stalls, the result register holds its word and the
// input register can still take one more word; in_stall rises only when
// both are full.
// Reset (rst_n low, synchronous) empties both registers, clears detector
// and command state and loads confirm_count=5, idle_limit=10,
// drive_speed=100. The APB port writes at 0x0, 0x4, 0x8; write only while
// the block holds no word in flight.
// ----------------------------------------------------------------------------
// line_junction_classifier_core
// Classifies line crossings from sensor samples and issues turn commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module line_junction_classifier_core
  import ljc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire ljc_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output ljc_out_t         out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // configuration
  logic [3:0] confirm_r;
  logic [7:0] idle_lim_r;
  logic [7:0] speed_cfg_r;

  // input register and result register
  ljc_in_t  pipe_r;
  logic     pipe_v_r;
  ljc_out_t out_r;
  logic     out_v_r;

  // detector state
  logic [2:0] found_r, found_nxt;
  logic [3:0] hits_r, hits_nxt;
  logic [7:0] miss_r, miss_nxt;
  logic       both_r, both_nxt;
  logic       centre_r, centre_nxt;
  logic [2:0] code_r, code_nxt;
  logic [7:0] amount_r, amount_nxt;
  logic       right_r, right_nxt;
  logic       rotate_r, rotate_nxt;
  logic       move_r, move_nxt;
  logic [7:0] speed_r, speed_nxt;

  logic       fire;
  logic       in_take;
  logic       cfg_wr;
  logic [7:0] s;
  logic       dead;
  logic       clr;
  logic [7:0] miss_inc;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign fire    = pipe_v_r && (!out_v_r || !out_stall);
  assign in_stall = pipe_v_r && out_v_r && out_stall;
  assign in_take = in_valid && !in_stall;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    unique case (paddr[3:2])
      REG_CONFIRM: prdata = {28'd0, confirm_r};
      REG_IDLE:    prdata = {24'd0, idle_lim_r};
      REG_SPEED:   prdata = {24'd0, speed_cfg_r};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      confirm_r   <= CONFIRM_RST;
      idle_lim_r  <= IDLE_RST;
      speed_cfg_r <= SPEED_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_CONFIRM: confirm_r   <= pwdata[3:0];
        REG_IDLE:    idle_lim_r  <= pwdata[7:0];
        REG_SPEED:   speed_cfg_r <= pwdata[7:0];
        default:     ;
      endcase
    end
  end

  // detector update for the word in the input register
  always_comb begin
    s          = pipe_r.line_sensors;
    dead       = (s & DEAD_MASK) == DEAD_MASK;
    miss_inc   = miss_r + 8'd1;
    clr        = 1'b0;
    found_nxt  = found_r;
    hits_nxt   = hits_r;
    miss_nxt   = miss_r;
    both_nxt   = both_r;
    centre_nxt = centre_r;
    code_nxt   = code_r;
    amount_nxt = amount_r;
    right_nxt  = right_r;
    rotate_nxt = rotate_r;
    move_nxt   = move_r;
    speed_nxt  = speed_r;

    if (pipe_r.timed_out && !dead && !both_r) begin
      clr = 1'b1;
    end else if (found_r != KIND_NONE) begin
      if (!pipe_r.motion_busy) begin
        code_nxt   = CMD_IDLE;
        rotate_nxt = 1'b0;
        move_nxt   = 1'b0;
      end
    end else begin
      if (both_r) begin
        // follow the crossing: centre first, then the far edge
        if (!centre_r) begin
          if ((s & DEAD_MASK) == 8'd0) centre_nxt = 1'b1;
        end else if (dead) begin
          found_nxt = KIND_T_LR;
        end else if ((s & EDGE_MASK) == EDGE_MASK && (s & MID_MASK) == 8'd0) begin
          found_nxt = KIND_FOUR_WAY;
        end
        hits_nxt = 4'd0;
      end else if (dead) begin
        found_nxt = KIND_DEAD_END;
      end else if ((s & BOTH_MASK) == BOTH_MASK) begin
        code_nxt  = CMD_AHEAD;
        right_nxt = 1'b0;
        speed_nxt = speed_cfg_r;
        both_nxt  = 1'b1;
      end else if ((s & RIGHT_MASK) == RIGHT_MASK) begin
        if (hits_r < confirm_r) hits_nxt = hits_r + 4'd1;
        else found_nxt = KIND_RIGHT_STR;
      end else if ((s & LEFT_MASK) == LEFT_MASK) begin
        if (hits_r < confirm_r) hits_nxt = hits_r + 4'd1;
        else found_nxt = KIND_LEFT_STR;
      end else begin
        miss_nxt = miss_inc;
        if (miss_inc > idle_lim_r) clr = 1'b1;
      end

      // turn table
      if (found_nxt == KIND_DEAD_END) begin
        amount_nxt = AMOUNT_180;
        right_nxt  = 1'b1;
        rotate_nxt = 1'b1;
        code_nxt   = CMD_RIGHT_180;
      end else if (found_nxt == KIND_LEFT_STR) begin
        amount_nxt = AMOUNT_40;
        right_nxt  = 1'b0;
        move_nxt   = 1'b1;
        code_nxt   = CMD_FWD_40;
      end else if (found_nxt != KIND_NONE) begin
        amount_nxt = AMOUNT_90;
        right_nxt  = 1'b1;
        rotate_nxt = 1'b1;
        code_nxt   = CMD_RIGHT_90;
      end
    end

    if (clr) begin
      miss_nxt   = 8'd0;
      hits_nxt   = 4'd0;
      found_nxt  = KIND_NONE;
      both_nxt   = 1'b0;
      centre_nxt = 1'b0;
      code_nxt   = CMD_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      found_r  <= KIND_NONE;
      hits_r   <= 4'd0;
      miss_r   <= 8'd0;
      both_r   <= 1'b0;
      centre_r <= 1'b0;
      code_r   <= CMD_IDLE;
      amount_r <= 8'd0;
      right_r  <= 1'b0;
      rotate_r <= 1'b0;
      move_r   <= 1'b0;
      speed_r  <= 8'd0;
    end else begin
      if (in_take) pipe_v_r <= 1'b1;
      else if (fire) pipe_v_r <= 1'b0;

      if (fire) out_v_r <= 1'b1;
      else if (!out_stall) out_v_r <= 1'b0;

      if (fire) begin
        found_r  <= found_nxt;
        hits_r   <= hits_nxt;
        miss_r   <= miss_nxt;
        both_r   <= both_nxt;
        centre_r <= centre_nxt;
        code_r   <= code_nxt;
        amount_r <= amount_nxt;
        right_r  <= right_nxt;
        rotate_r <= rotate_nxt;
        move_r   <= move_nxt;
        speed_r  <= speed_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) pipe_r <= in_data;
    if (fire) begin
      out_r.junction_kind <= found_nxt;
      out_r.command_code  <= code_nxt;
      out_r.move_amount   <= amount_nxt;
      out_r.turn_right    <= right_nxt;
      out_r.rotate_flag   <= rotate_nxt;
      out_r.move_flag     <= move_nxt;
      out_r.wheel_speed   <= speed_nxt;
    end
  end

  `include "line_junction_classifier_core_assert.svh"

  `LJC_ASSERT_IMP(a_centre_needs_both, centre_r, both_r, "centre passed without both sides")
  `LJC_ASSERT_IMP(a_found_not_ahead, found_r != KIND_NONE, code_r != CMD_AHEAD, "ahead after find")
  `LJC_ASSERT_NXT(a_fire_gives_result, fire, out_v_r, "result word lost")

endmodule

`default_nettype wire

[verif/tb_line_junction_classifier_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line junction classifier testbench
// Feeds sensor words through the valid/stall channel with random sender and
// receiver gaps, predicts every result word from an internal crossing tracker,
// and reprograms the three registers over APB between phases.
// ----------------------------------------------------------------------------

module tb_line_junction_classifier_core;
  import ljc_pkg::*;

  typedef enum logic [1:0] {PACE_SLOW_RX, PACE_SLOW_TX, PACE_FULL} pace_e;

  class crossing_tracker;
    logic [3:0] confirm_cnt;
    logic [7:0] idle_lim;
    logic [7:0] speed_set;
    logic [2:0] kind;
    logic [3:0] hits;
    logic [7:0] misses;
    logic       both_seen;
    logic       centre_seen;
    logic [2:0] code;
    logic [7:0] amount;
    logic [7:0] speed;
    logic       right;
    logic       rotate;
    logic       move;
    ljc_out_t   expected_words[$];
    int         errors;

    function new();
      confirm_cnt = CONFIRM_RST;
      idle_lim    = IDLE_RST;
      speed_set   = SPEED_RST;
      clear_crossing();
      amount = 8'd0;
      speed  = 8'd0;
      right  = 1'b0;
      rotate = 1'b0;
      move   = 1'b0;
      errors = 0;
    endfunction

    // command fields other than the code survive a clear
    function void clear_crossing();
      misses      = 8'd0;
      hits        = 4'd0;
      kind        = KIND_NONE;
      both_seen   = 1'b0;
      centre_seen = 1'b0;
      code        = CMD_IDLE;
    endfunction

    function void set_reg(input logic [1:0] idx, input logic [7:0] val);
      case (idx)
        REG_CONFIRM: confirm_cnt = val[3:0];
        REG_IDLE:    idle_lim = val;
        REG_SPEED:   speed_set = val;
        default: ;
      endcase
    endfunction

    function void count_side(input logic [2:0] k);
      if (hits < confirm_cnt) hits = hits + 4'd1;
      else kind = k;
    endfunction

    function void record_sample(input ljc_in_t w);
      logic [7:0] s;
      logic       dead;
      s = w.line_sensors;
      dead = (s & DEAD_MASK) == DEAD_MASK;
      if (w.timed_out && !dead && !both_seen) begin
        clear_crossing();
      end else if (kind != KIND_NONE) begin
        if (!w.motion_busy) begin
          code   = CMD_IDLE;
          rotate = 1'b0;
          move   = 1'b0;
        end
      end else begin
        if (both_seen) begin
          if (!centre_seen) begin
            if ((s & DEAD_MASK) == 8'h00) centre_seen = 1'b1;
          end else if (dead) begin
            kind = KIND_T_LR;
          end else if ((s & EDGE_MASK) == EDGE_MASK && (s & MID_MASK) == 8'h00) begin
            kind = KIND_FOUR_WAY;
          end
          hits = 4'd0;
        end else if (dead) begin
          kind = KIND_DEAD_END;
        end else if ((s & BOTH_MASK) == BOTH_MASK) begin
          code      = CMD_AHEAD;
          right     = 1'b0;
          speed     = speed_set;
          both_seen = 1'b1;
        end else if ((s & RIGHT_MASK) == RIGHT_MASK) begin
          count_side(KIND_RIGHT_STR);
        end else if ((s & LEFT_MASK) == LEFT_MASK) begin
          count_side(KIND_LEFT_STR);
        end else begin
          misses = misses + 8'd1;
          if (misses > idle_lim) clear_crossing();
        end
        // turn table: rotations keep the move flag, moves keep the rotate flag
        case (kind)
          KIND_NONE: ;
          KIND_DEAD_END: begin
            amount = AMOUNT_180;
            right  = 1'b1;
            rotate = 1'b1;
            code   = CMD_RIGHT_180;
          end
          KIND_LEFT_STR: begin
            amount = AMOUNT_40;
            right  = 1'b0;
            move   = 1'b1;
            code   = CMD_FWD_40;
          end
          default: begin
            amount = AMOUNT_90;
            right  = 1'b1;
            rotate = 1'b1;
            code   = CMD_RIGHT_90;
          end
        endcase
      end
      expected_words.push_back({kind, code, amount, right, rotate, move, speed});
    endfunction

    function void field_check(input string name, input int exp_v, input int got_v);
      if (exp_v != got_v) begin
        $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_word(input ljc_out_t got);
      ljc_out_t e;
      if (expected_words.size() == 0) begin
        $display("%0t: result word with none expected, expected nothing got %h", $time, got);
        errors++;
      end else begin
        e = expected_words.pop_front();
        field_check("junction_kind", int'(e.junction_kind), int'(got.junction_kind));
        field_check("command_code", int'(e.command_code), int'(got.command_code));
        field_check("move_amount", int'(e.move_amount), int'(got.move_amount));
        field_check("turn_right", int'(e.turn_right), int'(got.turn_right));
        field_check("rotate_flag", int'(e.rotate_flag), int'(got.rotate_flag));
        field_check("move_flag", int'(e.move_flag), int'(got.move_flag));
        field_check("wheel_speed", int'(e.wheel_speed), int'(got.wheel_speed));
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  ljc_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  ljc_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  crossing_tracker tracker;
  int sent;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_left;

  line_junction_classifier_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

  // input monitor
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) tracker.record_sample(in_data);
  end

  // receiver: checks words and stalls at random or for a long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) tracker.check_word(out_data);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  task automatic set_pace(input pace_e p);
    case (p)
      PACE_SLOW_RX: begin
        tx_idle_pct = 24;
        rx_idle_pct = 63;
      end
      PACE_SLOW_TX: begin
        tx_idle_pct = 63;
        rx_idle_pct = 24;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    endcase
  endtask

  task automatic send(input logic [7:0] s, input logic t, input logic b);
    in_valid <= 1'b1;
    in_data  <= {s, t, b};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // stop offering words and wait until every result word has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    logic [7:0] mask;
    mask = (idx == REG_CONFIRM) ? 8'h0F : 8'hFF;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val & mask};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    tracker.set_reg(idx, val & mask);
    // read it back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if ((prdata[7:0] & mask) != (val & mask)) begin
      $display("%0t: register %0d readback expected %0d got %0d", $time, idx,
               val & mask, prdata[7:0] & mask);
      tracker.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_regs(input logic [3:0] c, input logic [7:0] i, input logic [7:0] sp);
    write_reg(REG_CONFIRM, {4'd0, c});
    write_reg(REG_IDLE, i);
    write_reg(REG_SPEED, sp);
  endtask

  // no dead end, no side branch
  function automatic logic [7:0] plain_line();
    logic [7:0] s;
    do s = 8'($urandom);
    while ((s & DEAD_MASK) == DEAD_MASK || (s & RIGHT_MASK) == RIGHT_MASK ||
           (s & LEFT_MASK) == LEFT_MASK);
    return s;
  endfunction

  function automatic logic [7:0] side_byte(input logic go_right);
    logic [7:0] s;
    do s = go_right ? (8'($urandom) | RIGHT_MASK) : (8'($urandom) | LEFT_MASK);
    while ((s & DEAD_MASK) == DEAD_MASK ||
           (s & (go_right ? LEFT_MASK : RIGHT_MASK)) == (go_right ? LEFT_MASK : RIGHT_MASK));
    return s;
  endfunction

  // anything but a both-sides pattern, which would lock the detector early
  function automatic logic [7:0] stray_byte();
    logic [7:0] s;
    s = 8'($urandom);
    if ((s & BOTH_MASK) == BOTH_MASK && (s & DEAD_MASK) != DEAD_MASK) s[1] = 1'b0;
    return s;
  endfunction

  task automatic drive_approach();
    int pick;
    int n;
    pick = $urandom_range(0, 9);
    if (pick >= 8) begin
      repeat ($urandom_range(3, 12))
        send(stray_byte(), $urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
    end else begin
      repeat ($urandom_range(0, 3)) send(plain_line(), 1'b0, 1'($urandom_range(0, 1)));
      if (pick < 2) begin
        send(8'($urandom) | DEAD_MASK, 1'b0, 1'($urandom_range(0, 1)));
      end else begin
        n = tracker.confirm_cnt + $urandom_range(0, 2);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) send(plain_line(), 1'b0, 1'($urandom_range(0, 1)));
          send(side_byte(pick < 5), $urandom_range(0, 29) == 0, 1'($urandom_range(0, 1)));
        end
      end
      repeat ($urandom_range(0, 4)) send(stray_byte(), 1'b0, 1'b1);
      send(stray_byte(), 1'b0, 1'b0);
      if ($urandom_range(0, 7) != 0) send(plain_line(), 1'b1, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic drive_until(input int target);
    int third;
    third = sent + (target - sent) / 3;
    while (sent < third) drive_approach();
    hold_left <= 48;
    while (sent < 2 * third - (target - (target - sent))) drive_approach();
    while (sent < third + (target - third) / 2) drive_approach();
    settle();
    while (sent < target) drive_approach();
  endtask

  // straddles a crossing with both sides lit; afterwards the detector stays locked
  task automatic drive_through_crossing();
    logic [7:0] s;
    send(plain_line(), 1'b1, 1'($urandom_range(0, 1)));
    s = 8'($urandom) | BOTH_MASK;
    s[3'($urandom_range(3, 4))] = 1'b0;
    send(s, 1'b0, 1'($urandom_range(0, 1)));
    repeat ($urandom_range(1, 5)) begin
      do s = 8'($urandom);
      while ((s & DEAD_MASK) == 8'h00);
      send(s, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    send(8'($urandom) & ~DEAD_MASK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, 5)) begin
      do s = 8'($urandom);
      while ((s & DEAD_MASK) == DEAD_MASK ||
             ((s & EDGE_MASK) == EDGE_MASK && (s & MID_MASK) == 8'h00));
      send(s, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 1)) s = 8'($urandom) | DEAD_MASK;
    else s = (8'($urandom) | EDGE_MASK) & ~MID_MASK;
    send(s, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    repeat (40) send(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    tracker   = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    sent      = 0;
    hold_left = 0;
    set_pace(PACE_SLOW_RX);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // dead end, command idled once motion is not busy, then timeout clear
    send(8'hFF, 1'b0, 1'b1);
    send(8'h00, 1'b0, 1'b0);
    send(8'h00, 1'b1, 1'b0);
    // dead end wins over a timeout
    send(8'hFF, 1'b1, 1'b1);
    send(8'h81, 1'b1, 1'b0);
    // right branch confirms on the sixth word at the reset confirm count
    repeat (6) send(8'hE0, 1'b0, 1'b0);
    send(8'h24, 1'b1, 1'b0);
    repeat (6) send(8'h07, 1'b0, 1'b1);
    send(8'h18, 1'b1, 1'b0);
    // misses past the idle limit clear the detector
    repeat (11) send(8'h18, 1'b0, 1'b0);

    drive_until(300);
    settle();
    load_regs(4'd0, 8'd0, 8'd255);
    drive_until(600);

    set_pace(PACE_SLOW_TX);
    settle();
    load_regs(4'd15, 8'd255, 8'd0);
    drive_until(900);
    settle();
    load_regs(4'd3, 8'd7, 8'($urandom_range(1, 254)));
    drive_until(1200);

    set_pace(PACE_FULL);
    settle();
    load_regs(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
    drive_until(1500);
    settle();
    load_regs(4'($urandom_range(0, 15)), 8'($urandom_range(1, 20)),
              8'($urandom_range(0, 255)));
    drive_until(1720);

    set_pace(PACE_SLOW_RX);
    settle();
    write_reg(REG_SPEED, $urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(0, 255)));
    drive_through_crossing();

    settle();
    repeat (6) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
